// ----- hw/rtl/dqap_pkg.sv -----
// types and constants shared by the dotted-quad address parser
package dqap_pkg;

  // parse phase of the current string
  typedef enum logic [1:0] {
    PH_LEAD = 2'd0,  // skipping leading spaces
    PH_ADDR = 2'd1,  // inside the address
    PH_DONE = 2'd2,  // ended by a trailing space
    PH_ERR  = 2'd3   // error seen, ignore until end
  } phase_t;

  localparam logic [7:0]  CHAR_SPACE = 8'h20;
  localparam logic [7:0]  CHAR_DOT   = 8'h2E;
  localparam logic [7:0]  CHAR_ZERO  = 8'h30;
  localparam logic [7:0]  CHAR_NINE  = 8'h39;
  localparam logic [11:0] OCTET_MAX  = 12'd255;
  localparam logic [1:0]  MAX_DOTS   = 2'd3;

  // one registered input word
  typedef struct packed {
    logic [7:0] character;
    logic       char_present;
    logic       end_of_string;
  } item_t;

  // one result word
  typedef struct packed {
    logic        ok;
    logic [31:0] address;
  } result_t;

endpackage

// ----- hw/rtl/dqap_in_reg.sv -----
// input register stage of the dotted-quad address parser
module dqap_in_reg (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  dqap_pkg::item_t in_item,
  output logic            item_valid,
  output dqap_pkg::item_t item,
  input  logic            item_taken
);

  assign in_ready = !item_valid || item_taken;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_ready) begin
      item_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      item <= in_item;
    end
  end

endmodule

// ----- hw/rtl/dqap_parser.sv -----
// parse state update and result register of the dotted-quad address parser
module dqap_parser (
  input  logic                clk,
  input  logic                rst,
  input  logic                item_valid,
  input  dqap_pkg::item_t     item,
  output logic                item_taken,
  output logic                res_valid,
  input  logic                res_ready,
  output dqap_pkg::result_t   res
);

  dqap_pkg::phase_t phase, phase_next;
  logic [7:0]  octet_value, octet_value_next;
  logic [1:0]  dot_count, dot_count_next;
  logic [23:0] upper_octets, upper_octets_next;
  logic [11:0] digit_sum;
  logic        is_digit;
  logic        in_addr;
  logic        good;
  dqap_pkg::result_t res_next;

  // a word without end always moves on; a word with end needs the result slot
  assign item_taken = item_valid &&
                      (!item.end_of_string || !res_valid || res_ready);

  assign is_digit  = (item.character >= dqap_pkg::CHAR_ZERO) &&
                     (item.character <= dqap_pkg::CHAR_NINE);
  // octet * 10 + digit
  assign digit_sum = {1'b0, octet_value, 3'b000} + {3'b000, octet_value, 1'b0}
                   + {4'd0, item.character - dqap_pkg::CHAR_ZERO};
  assign in_addr   = (phase == dqap_pkg::PH_ADDR) ||
                     ((phase == dqap_pkg::PH_LEAD) && (item.character != dqap_pkg::CHAR_SPACE));

  // next parse state after this character
  always_comb begin
    phase_next        = phase;
    octet_value_next  = octet_value;
    dot_count_next    = dot_count;
    upper_octets_next = upper_octets;
    if (item.char_present && in_addr) begin
      phase_next = dqap_pkg::PH_ADDR;
      if (item.character == dqap_pkg::CHAR_DOT) begin
        if (dot_count == dqap_pkg::MAX_DOTS) begin
          phase_next = dqap_pkg::PH_ERR;
        end else begin
          dot_count_next    = dot_count + 2'd1;
          upper_octets_next = {upper_octets[15:0], octet_value};
          octet_value_next  = 8'd0;
        end
      end else if (is_digit) begin
        if (digit_sum > dqap_pkg::OCTET_MAX) begin
          phase_next = dqap_pkg::PH_ERR;
        end else begin
          octet_value_next = digit_sum[7:0];
        end
      end else if (item.character == dqap_pkg::CHAR_SPACE) begin
        phase_next = dqap_pkg::PH_DONE;
      end else begin
        phase_next = dqap_pkg::PH_ERR;
      end
    end
  end

  // result seen on the end word
  always_comb begin
    good = ((phase_next == dqap_pkg::PH_ADDR) || (phase_next == dqap_pkg::PH_DONE)) &&
           (dot_count_next == dqap_pkg::MAX_DOTS);
    res_next.ok      = good;
    res_next.address = good ? {upper_octets_next, octet_value_next} : 32'd0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= dqap_pkg::PH_LEAD;
      octet_value  <= 8'd0;
      dot_count    <= 2'd0;
      upper_octets <= 24'd0;
    end else if (item_taken) begin
      if (item.end_of_string) begin
        phase        <= dqap_pkg::PH_LEAD;
        octet_value  <= 8'd0;
        dot_count    <= 2'd0;
        upper_octets <= 24'd0;
      end else begin
        phase        <= phase_next;
        octet_value  <= octet_value_next;
        dot_count    <= dot_count_next;
        upper_octets <= upper_octets_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (item_taken && item.end_of_string) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item_taken && item.end_of_string) begin
      res <= res_next;
    end
  end

endmodule

// ----- hw/rtl/dotted_quad_address_parser_unit.sv -----
// top level: dotted-quad ipv4 address parser, one character per word
// an end word passes the input register, then the result register, and waits
//   in the input register while the result slot is full
// throughput: one word per cycle, except that an end word stalls while the result
//   slot is full; the octet update (octet * 10 + digit and compare) is combinational
// reset: rst (synchronous) empties both registers and returns the parser
//   to the leading-spaces phase with all octets and the dot count cleared
module dotted_quad_address_parser_unit (
  input  logic        clk,
  input  logic        rst,
  // input words
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] character
  input  logic        s_axis_tuser,   // [0] char_present
  input  logic        s_axis_tlast,   // end_of_string
  // result words
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [31:0] address
  output logic        m_axis_tuser    // [0] ok
);

  dqap_pkg::item_t   in_item;
  dqap_pkg::item_t   item;
  dqap_pkg::result_t res;
  logic              item_valid;
  logic              item_taken;

  assign in_item.character     = s_axis_tdata;
  assign in_item.char_present  = s_axis_tuser;
  assign in_item.end_of_string = s_axis_tlast;

  // input register; refills in the same cycle its word moves on
  dqap_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_axis_tvalid),
    .in_ready   (s_axis_tready),
    .in_item    (in_item),
    .item_valid (item_valid),
    .item       (item),
    .item_taken (item_taken)
  );

  // parse state and result register; stalls only an end word on a full slot
  dqap_parser u_parser (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item       (item),
    .item_taken (item_taken),
    .res_valid  (m_axis_tvalid),
    .res_ready  (m_axis_tready),
    .res        (res)
  );

  assign m_axis_tdata = res.address;
  assign m_axis_tuser = res.ok;

endmodule

// ----- tb/tb_dotted_quad_address_parser_unit.sv -----
// testbench for the dotted-quad address parser: directed and random strings checked word by word
`timescale 1ns / 100ps

module tb_dotted_quad_address_parser_unit;

  localparam int HOLD_CYCLES    = 300;   // long receiver hold-off
  localparam int WATCHDOG_LIMIT = 4000;  // cycles with no word moving on either side
  localparam int DRAIN_CYCLES   = 10;    // drain time before the final report
  localparam int PHASE_ITEMS    = 220;   // character words per random phase
  localparam int MAX_PRINTS     = 50;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;   // [7:0] character
  logic        s_axis_tuser = 1'b0; // [0] char_present
  logic        s_axis_tlast = 1'b0; // end_of_string
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;        // [31:0] address
  logic        m_axis_tuser;        // [0] ok

  dotted_quad_address_parser_unit u_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #5 clk = ~clk;

  // words waiting to be offered, and results the parser owes us
  dqap_pkg::item_t   pending_words[$];
  dqap_pkg::result_t expected_results[$];
  logic [7:0]        text_buf[$];
  dqap_pkg::item_t   next_word;

  // shadow copy of the parser state
  dqap_pkg::phase_t sh_phase = dqap_pkg::PH_LEAD;
  logic [7:0]       sh_octet = '0;
  logic [1:0]       sh_dots  = '0;
  logic [23:0]      sh_upper = '0;

  int src_idle_pct  = 0;
  int rx_stall_pct  = 0;
  int blank_pct     = 0;
  bit hold_req      = 1'b0;
  bit hold_seen     = 1'b0;
  int hold_left     = 0;
  int idle_cycles   = 0;

  int stim_items    = 0;
  int n_strings     = 0;
  int n_good        = 0;
  int n_rejected    = 0;
  int n_checked     = 0;
  int n_errors      = 0;

  task automatic report_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
    if (n_errors < MAX_PRINTS)
      $display("mismatch at result %0d: %s expected %h got %h", n_checked, what, want, got);
    n_errors++;
  endtask

  // advance the shadow parser by one accepted word; an end word yields one result
  task automatic parse_word(input logic [7:0] ch, input logic present, input logic last);
    logic [11:0]       cand;
    dqap_pkg::result_t r;
    if (present) begin
      if (sh_phase == dqap_pkg::PH_LEAD && ch != dqap_pkg::CHAR_SPACE)
        sh_phase = dqap_pkg::PH_ADDR;
      if (sh_phase == dqap_pkg::PH_ADDR) begin
        if (ch == dqap_pkg::CHAR_DOT) begin
          if (sh_dots == dqap_pkg::MAX_DOTS) begin
            sh_phase = dqap_pkg::PH_ERR;  // fourth dot
          end else begin
            sh_dots  = sh_dots + 2'd1;
            sh_upper = {sh_upper[15:0], sh_octet};
            sh_octet = '0;
          end
        end else if (ch >= dqap_pkg::CHAR_ZERO && ch <= dqap_pkg::CHAR_NINE) begin
          cand = {4'd0, sh_octet} * 12'd10 + {4'd0, ch - dqap_pkg::CHAR_ZERO};
          if (cand > dqap_pkg::OCTET_MAX) sh_phase = dqap_pkg::PH_ERR;
          else sh_octet = cand[7:0];
        end else if (ch == dqap_pkg::CHAR_SPACE) begin
          sh_phase = dqap_pkg::PH_DONE;
        end else begin
          sh_phase = dqap_pkg::PH_ERR;
        end
      end
    end
    if (last) begin
      r.ok      = (sh_phase == dqap_pkg::PH_ADDR || sh_phase == dqap_pkg::PH_DONE) &&
                  sh_dots == dqap_pkg::MAX_DOTS;
      r.address = r.ok ? {sh_upper, sh_octet} : 32'd0;
      expected_results.push_back(r);
      if (r.ok) n_good++;
      else n_rejected++;
      sh_phase = dqap_pkg::PH_LEAD;
      sh_octet = '0;
      sh_dots  = '0;
      sh_upper = '0;
    end
  endtask

  // word with neither flag set: the parser must ignore it
  task automatic push_blank();
    dqap_pkg::item_t w;
    w.character     = 8'($urandom_range(255));
    w.char_present  = 1'b0;
    w.end_of_string = 1'b0;
    pending_words.push_back(w);
  endtask

  task automatic text_add(input string s);
    for (int i = 0; i < s.len(); i++) text_buf.push_back(s[i]);
  endtask

  // queue the text buffer as one string; the end flag rides on the last
  // character or on a separate word with no character
  task automatic send_text(input bit end_on_char);
    dqap_pkg::item_t w;
    int              n;
    n = text_buf.size();
    for (int i = 0; i < n; i++) begin
      if (blank_pct != 0 && $urandom_range(99) < blank_pct) push_blank();
      w.character     = text_buf[i];
      w.char_present  = 1'b1;
      w.end_of_string = end_on_char && (i == n - 1);
      pending_words.push_back(w);
      stim_items++;
    end
    if (n == 0 || !end_on_char) begin
      w.character     = 8'($urandom_range(255));
      w.char_present  = 1'b0;
      w.end_of_string = 1'b1;
      pending_words.push_back(w);
      stim_items++;
    end
    text_buf.delete();
    n_strings++;
  endtask

  function automatic string octet_text(input int v);
    string s;
    s = $sformatf("%0d", v);
    if ($urandom_range(9) == 0) s = {"0", s};
    if ($urandom_range(19) == 0) s = {"00", s};
    return s;
  endfunction

  function automatic int pick_octet();
    int r;
    r = $urandom_range(9);
    if (r == 0) return 255;
    if (r == 1) return 0;
    if (r == 2) return $urandom_range(9);
    return $urandom_range(255);
  endfunction

  // mostly well-formed addresses with random content, the rest broken or noise
  task automatic gen_random_string();
    int    kind;
    int    n_oct;
    int    bad_at;
    int    r;
    string noise_chars;
    noise_chars = " .0123456789x";
    kind   = $urandom_range(99);
    n_oct  = 4;
    bad_at = -1;
    if (kind >= 80 && kind < 87) begin
      n_oct = $urandom_range(1, 5);
      if (n_oct == 4) n_oct = 5;
    end
    if (kind >= 70 && kind < 80) bad_at = $urandom_range(3);
    r = $urandom_range(9);
    if (r < 2) text_add(" ");
    if (r == 0) text_add("  ");
    if (kind >= 94) begin
      // raw noise, half from the full byte range, half from parser-relevant characters
      for (int i = $urandom_range(1, 8); i > 0; i--) begin
        if ($urandom_range(1)) text_buf.push_back(8'($urandom_range(255)));
        else text_buf.push_back(noise_chars[$urandom_range(12)]);
      end
    end else begin
      for (int i = 0; i < n_oct; i++) begin
        if (i != 0) text_add(".");
        if (i == bad_at) text_add($sformatf("%0d", $urandom_range(256, 2999)));
        else if ($urandom_range(24) != 0) text_add(octet_text(pick_octet()));
      end
      if (kind >= 87 && text_buf.size() != 0)
        text_buf[$urandom_range(text_buf.size() - 1)] = 8'($urandom_range(255));
      if ($urandom_range(3) == 0) begin
        text_add(" ");
        for (int i = $urandom_range(4); i > 0; i--)
          text_buf.push_back(8'($urandom_range(255)));
      end
    end
    send_text(1'($urandom_range(1)));
  endtask

  task automatic wait_idle();
    do @(negedge clk);
    while (pending_words.size() != 0 || s_axis_tvalid || expected_results.size() != 0);
  endtask

  task automatic run_random(input int src_pct, input int rx_pct);
    int target;
    src_idle_pct = src_pct;
    rx_stall_pct = rx_pct;
    blank_pct    = 3;
    target       = stim_items + PHASE_ITEMS;
    while (stim_items < target) gen_random_string();
    wait_idle();
  endtask

  // input side: offer queued words, hold each until it is taken
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready)
        parse_word(s_axis_tdata, s_axis_tuser, s_axis_tlast);
      if (!s_axis_tvalid || s_axis_tready) begin
        if (pending_words.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
          next_word = pending_words.pop_front();
          s_axis_tdata  <= next_word.character;
          s_axis_tuser  <= next_word.char_present;
          s_axis_tlast  <= next_word.end_of_string;
          s_axis_tvalid <= 1'b1;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // result side ready: random stalls, plus a long hold-off on request
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else if (hold_req != hold_seen) begin
      hold_seen     <= hold_req;
      hold_left     <= HOLD_CYCLES;
      m_axis_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left     <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  // check each result word against the oldest expectation
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected result word", 32'd0, m_axis_tdata);
      end else begin
        if (m_axis_tuser !== expected_results[0].ok)
          report_mismatch("ok flag", {31'd0, expected_results[0].ok}, {31'd0, m_axis_tuser});
        if (m_axis_tdata !== expected_results[0].address)
          report_mismatch("address", expected_results[0].address, m_axis_tdata);
        void'(expected_results.pop_front());
      end
      n_checked++;
    end
  end

  // watchdog on cycles where no word moves
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no word moved for %0d cycles", WATCHDOG_LIMIT);
      $display("tb_dotted_quad_address_parser_unit: FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed strings
    push_blank();
    text_add("0.0.0.0");             send_text(1'b1);
    text_add("255.255.255.255");     send_text(1'b0);
    text_add("  10.20.30.40");       send_text(1'b1);
    text_add("1.2.3.4 z9");          send_text(1'b1);  // trailing space, rest ignored
    text_add("1..2.3");              send_text(1'b1);  // empty octet is zero
    send_text(1'b0);                                   // empty string
    text_add("   ");                 send_text(1'b1);  // only spaces
    text_add("256.1.1.1");           send_text(1'b1);  // octet overflow
    text_add("1.1.1.2555");          send_text(1'b0);
    text_add("1.2.3.4.5");           send_text(1'b1);  // fourth dot
    text_add("1.2.a.4");             send_text(1'b1);  // stray character
    text_add("1.2.3");               send_text(1'b1);  // too few dots
    text_add("...");                 send_text(1'b1);
    text_add(" x");                  send_text(1'b0);
    text_add("9.8.7.6");
    text_buf.push_back(8'hFF);       send_text(1'b1);  // high-bit character is an error
    text_add("001.010.100.099");     send_text(1'b1);
    text_add("1.2.3.4 ");            send_text(1'b1);
    text_add("4.3.2.1 ");
    text_buf.push_back(8'h80);
    text_buf.push_back(8'h7F);
    text_add("...");                 send_text(1'b0);
    text_add("1.2x.3.4");            send_text(1'b1);  // digits after error ignored
    blank_pct = 50;
    text_add("12.34.56.78");         send_text(1'b0);  // blank words mixed in
    blank_pct = 0;
    push_blank();
    wait_idle();

    // no idling, with a long receiver hold while the sender keeps pushing
    src_idle_pct = 0;
    rx_stall_pct = 0;
    hold_req = ~hold_req;
    for (int i = 0; i < 30; i++) begin
      text_add($sformatf("%0d.%0d.%0d.%0d", $urandom_range(9), $urandom_range(9),
                         $urandom_range(9), $urandom_range(9)));
      send_text(1'b1);
    end
    run_random(0, 0);
    run_random(87, 0);
    run_random(0, 87);
    run_random(6, 6);

    repeat (DRAIN_CYCLES) @(negedge clk);
    $display("covered %0d strings over %0d words: %0d valid addresses, %0d rejected",
             n_strings, stim_items, n_good, n_rejected);
    $display("%0d results checked under no, sender, receiver and mixed idling; %0d mismatches",
             n_checked, n_errors);
    if (n_errors == 0 && expected_results.size() == 0) begin
      $display("tb_dotted_quad_address_parser_unit: PASS");
    end else begin
      $display("tb_dotted_quad_address_parser_unit: FAIL");
    end
    $finish;
  end

endmodule

// ----- dotted_quad_address_parser_unit.f -----
hw/rtl/dqap_pkg.sv
hw/rtl/dqap_in_reg.sv
hw/rtl/dqap_parser.sv
hw/rtl/dotted_quad_address_parser_unit.sv
tb/tb_dotted_quad_address_parser_unit.sv
